// ===== hdl/q4k_pkg.sv =====
// Shared types, constants and decode functions for the Q4_K dot-product block.
package q4k_pkg;

    localparam int ACT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 24;
    localparam int BLOCK_BYTES   = 128;
    localparam int POS_W         = $clog2(BLOCK_BYTES);
    localparam int SCALE_BYTES   = 12;
    localparam int FRAC_ALIGN    = 24;
    localparam int IN_DATA_W     = 168;
    localparam int OUT_DATA_W    = 64;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    localparam logic [63:0] INT64_MIN_C = {1'b1, 63'd0};
    localparam logic [63:0] INT64_MAX_C = {1'b0, {63{1'b1}}};

    typedef struct packed {
        logic               ok;
        logic signed [11:0] mant;
        logic signed [6:0]  ex;
    } t_half;

    typedef struct packed {
        logic [5:0] sc;
        logic [5:0] m;
    } t_sub;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] acc;
    } t_fold_res;

    // fp16 -> signed mantissa * 2^ex, ok low for inf/NaN
    function automatic t_half half_decode(input logic [15:0] h);
        t_half      r;
        logic [4:0] e;
        logic [11:0] f;
        e = h[14:10];
        f = {2'b00, h[9:0]};
        r.ok = (e != 5'd31);
        if (e == 5'd0) begin
            r.ex = -7'sd24;
        end else begin
            f = f + 12'd1024;
            r.ex = $signed({2'b00, e}) - 7'sd25;
        end
        r.mant = h[15] ? -$signed(f) : $signed(f);
        return r;
    endfunction

    // 6-bit scale and minimum of sub-block j from the twelve packed bytes
    function automatic t_sub sub_params(input logic [8*SCALE_BYTES-1:0] q,
                                        input logic [2:0] j);
        t_sub r;
        int   ji;
        ji = int'(j);
        if (j[2] == 1'b0) begin
            r.sc = q[8*ji +: 6];
            r.m  = q[8*(ji+4) +: 6];
        end else begin
            r.sc = {q[8*(ji-4)+6 +: 2], q[8*(ji+4) +: 4]};
            r.m  = {q[8*ji+6 +: 2], q[8*(ji+4)+4 +: 4]};
        end
        return r;
    endfunction

endpackage

// ===== hdl/q4k_dequant_dot_product_top.sv =====
// Top level: Q4_K dequantize dot product, two nibble lanes and a super-block fold unit.
//
// channel  dir  tdata                                    tuser        tlast
// s        in   168b: scale_half, min_half, packed_lo,   [0] mode     last
//               packed_hi, quant_byte, act_low, act_high
// m        out  64b: dot_value                           [0] overflowed  -
//
// A weight word is taken every cycle in the run state; the lanes and sum stage form a 3-deep pipeline.
// The last byte of a super-block or a last word stalls input through pipeline drain and
// the 5-step fold sequencer; a word that emits also waits in the emit state.
// A header mid-block starts the fold on its own edge and stalls input until the fold ends.
// A header word waits until the lane pipeline is empty.
// A result leaves through an output register; emit waits only while it is full.
// Reset (i_rst_n low, synchronous) clears header, scale bytes, sums and accumulator.
module q4k_dequant_dot_product_top import q4k_pkg::*; #(
    parameter int ACT_BITS  = ACT_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // scale_half, min_half, packed_lo, packed_hi, quant_byte, act_low, act_high
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // mode
    input  logic [0:0]            i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // dot_value
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // overflowed
    output logic [0:0]            o_m_tuser
);

    localparam int SSUM_W = ACT_BITS + 24;
    localparam int MSUM_W = ACT_BITS + 16;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_FOLD  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [15:0]             w_scale_half, w_min_half;
    logic [31:0]             w_packed_lo;
    logic [63:0]             w_packed_hi;
    logic [7:0]              w_quant;
    logic [15:0]             w_act_low, w_act_high;
    logic signed [ACT_BITS-1:0] w_x0, w_x1;

    assign w_scale_half = i_s_tdata[15:0];
    assign w_min_half   = i_s_tdata[31:16];
    assign w_packed_lo  = i_s_tdata[63:32];
    assign w_packed_hi  = i_s_tdata[127:64];
    assign w_quant      = i_s_tdata[135:128];
    assign w_act_low    = i_s_tdata[151:136];
    assign w_act_high   = i_s_tdata[167:152];

    generate
        if (ACT_BITS <= 16) begin : g_act_narrow
            assign w_x0 = w_act_low[ACT_BITS-1:0];
            assign w_x1 = w_act_high[ACT_BITS-1:0];
        end else begin : g_act_wide
            assign w_x0 = {{(ACT_BITS-16){w_act_low[15]}}, w_act_low};
            assign w_x1 = {{(ACT_BITS-16){w_act_high[15]}}, w_act_high};
        end
    endgenerate

    logic [1:0]                  r_state, n_state;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic                        r_s1v, r_s2v;
    logic                        r_emit, n_emit;
    logic [15:0]                 r_scale, n_scale, r_min, n_min;
    logic [8*SCALE_BYTES-1:0]    r_sbytes, n_sbytes;
    logic signed [SSUM_W-1:0]    r_ssum, n_ssum;
    logic signed [MSUM_W-1:0]    r_msum, n_msum;
    logic signed [63:0]          r_acc, n_acc;
    logic                        r_sat, n_sat;
    logic                        r_out_valid, n_out_valid;
    logic [63:0]                 r_out_data, n_out_data;
    logic                        r_out_flag, n_out_flag;

    logic      w_hdr, w_accept, w_fold_w, w_start, w_pipe_busy, w_out_free;
    t_sub      w_sub0, w_sub1;
    t_fold_res w_fold;
    logic signed [ACT_BITS+10:0] w_ps0, w_ps1;
    logic signed [ACT_BITS+6:0]  w_pm0, w_pm1;

    assign w_hdr       = (i_s_tuser[0] == MODE_HEADER);
    assign w_pipe_busy = r_s1v | r_s2v;
    assign o_s_tready  = (r_state == ST_RUN) && !(w_hdr && w_pipe_busy);
    assign w_accept    = i_s_tvalid & o_s_tready;
    assign w_fold_w    = i_s_tlast || (r_pos == POS_W'(BLOCK_BYTES - 1));
    assign w_start     = (w_accept && w_hdr && (r_pos != '0)) ||
                         (r_state == ST_DRAIN && !w_pipe_busy);
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign w_sub0 = sub_params(r_sbytes, {r_pos[POS_W-1 -: 2], 1'b0});
    assign w_sub1 = sub_params(r_sbytes, {r_pos[POS_W-1 -: 2], 1'b1});

    q4k_lane #(.ACT_BITS(ACT_BITS)) u_lane_lo (
        .i_clk    (i_clk),
        .i_sc     (w_sub0.sc),
        .i_m      (w_sub0.m),
        .i_q      (w_quant[3:0]),
        .i_x      (w_x0),
        .o_scaled (w_ps0),
        .o_min    (w_pm0)
    );

    q4k_lane #(.ACT_BITS(ACT_BITS)) u_lane_hi (
        .i_clk    (i_clk),
        .i_sc     (w_sub1.sc),
        .i_m      (w_sub1.m),
        .i_q      (w_quant[7:4]),
        .i_x      (w_x1),
        .o_scaled (w_ps1),
        .o_min    (w_pm1)
    );

    q4k_fold #(.ACT_BITS(ACT_BITS), .FRAC_BITS(FRAC_BITS)) u_fold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_scale_half (r_scale),
        .i_min_half   (r_min),
        .i_ssum       (r_ssum),
        .i_msum       (r_msum),
        .i_acc        (r_acc),
        .o_res        (w_fold)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_emit      = r_emit;
        n_scale     = r_scale;
        n_min       = r_min;
        n_sbytes    = r_sbytes;
        n_ssum      = r_ssum;
        n_msum      = r_msum;
        n_acc       = r_acc;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_flag  = r_out_flag;

        // lane merge into the running sums
        if (r_s2v) begin
            n_ssum = r_ssum + SSUM_W'(w_ps0) + SSUM_W'(w_ps1);
            n_msum = r_msum + MSUM_W'(w_pm0) + MSUM_W'(w_pm1);
        end

        unique case (r_state)
            ST_RUN: begin
                if (w_accept && w_hdr) begin
                    // old header stays on the fold inputs through the start edge
                    n_scale  = w_scale_half;
                    n_min    = w_min_half;
                    n_sbytes = {w_packed_hi, w_packed_lo};
                    n_pos    = '0;
                    if (r_pos != '0) begin
                        n_state = ST_FOLD;
                    end
                end else if (w_accept) begin
                    n_pos  = w_fold_w ? '0 : r_pos + 1'b1;
                    n_emit = i_s_tlast;
                    if (w_fold_w) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!w_pipe_busy) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (w_fold.done) begin
                    n_acc   = $signed(w_fold.acc);
                    n_sat   = r_sat | w_fold.sat;
                    n_ssum  = '0;
                    n_msum  = '0;
                    n_state = r_emit ? ST_EMIT : ST_RUN;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_out_flag  = r_sat;
                    n_acc       = '0;
                    n_sat       = 1'b0;
                    n_emit      = 1'b0;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_pos       <= '0;
            r_s1v       <= 1'b0;
            r_s2v       <= 1'b0;
            r_emit      <= 1'b0;
            r_scale     <= '0;
            r_min       <= '0;
            r_sbytes    <= '0;
            r_ssum      <= '0;
            r_msum      <= '0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_s1v       <= w_accept && !w_hdr;
            r_s2v       <= r_s1v;
            r_emit      <= n_emit;
            r_scale     <= n_scale;
            r_min       <= n_min;
            r_sbytes    <= n_sbytes;
            r_ssum      <= n_ssum;
            r_msum      <= n_msum;
            r_acc       <= n_acc;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_flag <= n_out_flag;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_flag;

`ifndef SYNTH
    a_fold_start_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_pipe_busy)
        else $error("fold started with lane words in flight");

    a_fold_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fold.done |-> (r_state == ST_FOLD))
        else $error("fold result outside fold state");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_s_tready)
        else $error("input ready while folding or emitting");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_out_valid) |=> r_out_valid)
        else $error("emit did not load output register");
`endif

endmodule

// ===== hdl/q4k_lane.sv =====
// One nibble lane: sub-block scale times weight, then both products with the activation.
module q4k_lane import q4k_pkg::*; #(
    parameter int ACT_BITS = ACT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic [5:0]                 i_sc,
    input  logic [5:0]                 i_m,
    input  logic [3:0]                 i_q,
    input  logic signed [ACT_BITS-1:0] i_x,
    output logic signed [ACT_BITS+10:0] o_scaled,
    output logic signed [ACT_BITS+6:0]  o_min
);

    logic [9:0]                 r_scq;
    logic [5:0]                 r_m;
    logic signed [ACT_BITS-1:0] r_x;
    logic signed [ACT_BITS+10:0] r_ps;
    logic signed [ACT_BITS+6:0]  r_pm;

    always_ff @(posedge i_clk) begin
        r_scq <= 10'(i_sc * i_q);
        r_m   <= i_m;
        r_x   <= i_x;
        r_ps  <= $signed({1'b0, r_scq}) * r_x;
        r_pm  <= $signed({1'b0, r_m}) * r_x;
    end

    assign o_scaled = r_ps;
    assign o_min    = r_pm;

endmodule

// ===== hdl/q4k_fold.sv =====
// Super-block fold: exact d*S - dmin*M scaled to fixed point, floored, saturating add.
module q4k_fold import q4k_pkg::*; #(
    parameter int ACT_BITS  = ACT_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [15:0]                 i_scale_half,
    input  logic [15:0]                 i_min_half,
    input  logic signed [ACT_BITS+23:0] i_ssum,
    input  logic signed [ACT_BITS+15:0] i_msum,
    input  logic signed [63:0]          i_acc,
    output t_fold_res                   o_res
);

    localparam int PA_W = ACT_BITS + 36;
    localparam int PB_W = ACT_BITS + 28;

    localparam logic [2:0] SP_IDLE  = 3'd0;
    localparam logic [2:0] SP_SPLIT = 3'd1;
    localparam logic [2:0] SP_SUB   = 3'd2;
    localparam logic [2:0] SP_BOR   = 3'd3;
    localparam logic [2:0] SP_ACC   = 3'd4;

    typedef struct packed {
        logic                  sat;
        logic [63:0]           ip;
        logic [FRAC_ALIGN-1:0] fr;
    } t_split;

    typedef struct packed {
        logic        sat;
        logic [63:0] v;
    } t_sat;

    // v * 2^s as floor part plus fraction left-aligned to FRAC_ALIGN bits
    function automatic t_split split_term(input logic signed [63:0] v,
                                          input logic signed [7:0] s);
        t_split             r;
        logic signed [127:0] w;
        logic [5:0]         k;
        logic [63:0]        t;
        r = '0;
        if (!s[7]) begin
            w = 128'(v) <<< s[5:0];
            if (w[127:63] == {65{w[63]}}) begin
                r.ip = w[63:0];
            end else begin
                r.sat = 1'b1;
                r.ip  = w[127] ? INT64_MIN_C : INT64_MAX_C;
            end
        end else begin
            k    = 6'(-s);
            r.ip = v >>> k;
            t    = v << (6'(FRAC_ALIGN) - k);
            r.fr = t[FRAC_ALIGN-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_sum(input logic signed [63:0] a,
                                     input logic signed [63:0] b,
                                     input logic sub);
        t_sat              r;
        logic signed [64:0] d;
        d = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
        r.sat = d[64] ^ d[63];
        r.v   = r.sat ? (d[64] ? INT64_MIN_C : INT64_MAX_C) : d[63:0];
        return r;
    endfunction

    logic [2:0]              r_step, n_step;
    logic                    r_done, n_done;
    logic                    r_bad;
    logic                    r_sat, n_sat;
    logic signed [PA_W-1:0]  r_pa;
    logic signed [PB_W-1:0]  r_pb;
    logic signed [7:0]       r_sa, r_sb;
    logic [63:0]             r_ai, r_bi, r_r;
    logic [FRAC_ALIGN-1:0]   r_fa, r_fb;
    logic                    r_bor;
    logic [63:0]             r_res;

    t_half  w_hd, w_hm;
    t_split w_sa, w_sb;
    t_sat   w_sub, w_bor, w_acc;

    assign w_hd  = half_decode(i_scale_half);
    assign w_hm  = half_decode(i_min_half);
    assign w_sa  = split_term(64'(r_pa), r_sa);
    assign w_sb  = split_term(64'(r_pb), r_sb);
    assign w_sub = sat_sum(r_ai, r_bi, 1'b1);
    assign w_bor = sat_sum(r_r, 64'sd1, 1'b1);
    assign w_acc = sat_sum(i_acc, r_r, 1'b0);

    always_comb begin
        n_step = r_step;
        n_done = 1'b0;
        n_sat  = r_sat;
        unique case (r_step)
            SP_IDLE: begin
                if (i_start) begin
                    n_step = SP_SPLIT;
                    n_sat  = 1'b0;
                end
            end
            SP_SPLIT: begin
                n_step = SP_SUB;
                n_sat  = r_sat | w_sa.sat | w_sb.sat;
            end
            SP_SUB: begin
                n_step = SP_BOR;
                n_sat  = r_sat | w_sub.sat;
            end
            SP_BOR: begin
                n_step = SP_ACC;
                n_sat  = r_sat | (r_bor & w_bor.sat);
            end
            SP_ACC: begin
                n_step = SP_IDLE;
                n_done = 1'b1;
                n_sat  = r_bad | r_sat | w_acc.sat;
            end
            default: begin
                n_step = SP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SP_IDLE;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
            r_sat  <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_step)
            SP_IDLE: begin
                r_pa  <= i_ssum * w_hd.mant;
                r_pb  <= i_msum * w_hm.mant;
                r_sa  <= 8'($signed(w_hd.ex)) + 8'(FRAC_BITS);
                r_sb  <= 8'($signed(w_hm.ex)) + 8'(FRAC_BITS);
                r_bad <= !w_hd.ok || !w_hm.ok;
            end
            SP_SPLIT: begin
                r_ai <= w_sa.ip;
                r_fa <= w_sa.fr;
                r_bi <= w_sb.ip;
                r_fb <= w_sb.fr;
            end
            SP_SUB: begin
                r_r   <= w_sub.v;
                r_bor <= (r_fa < r_fb);
            end
            SP_BOR: begin
                if (r_bor) begin
                    r_r <= w_bor.v;
                end
            end
            SP_ACC: begin
                r_res <= r_bad ? i_acc : w_acc.v;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.acc  = r_res;

endmodule
